@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// Every property is sampled on clk_i and is off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property check.
`define ASSERT_P(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The condition must never be true.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ design/smc_pkg.sv @@
package smc_pkg;

  // Sizes
  localparam int MAX_PATTERN = 16;
  localparam int MAX_TEXT    = 65536;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 5;
  localparam int IDX_W       = 16;
  localparam int CNT_W       = 16;
  localparam int POS_W       = $clog2(MAX_TEXT + 2);
  localparam int SEL_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 2'd2;

  // Result item packing
  localparam int OUT_FIELD_W = 1 + IDX_W + CNT_W + 1;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  // One scanned byte on its way from the cell row to the accumulator
  typedef struct packed {
    logic             hit;
    logic             last;
    logic [IDX_W-1:0] start;
    logic             too_long;
  } scan_item_t;

endpackage

@@ design/smc_cell.sv @@
// One pattern byte of the row: remembers whether the pattern prefix ending
// at this byte matched the text ending at the previous byte.
module smc_cell import smc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  logic              clear_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic [BYTE_W-1:0] pat_byte_i,
  input  logic              chain_i,
  output logic              hit_o,
  output logic              chain_o
);

  logic chain_q, chain_d;

  // prefix extends by one byte when the neighbor matched and this byte agrees
  assign hit_o = chain_i & (byte_i == pat_byte_i);

  always_comb begin
    chain_d = chain_q;
    if (shift_i) begin
      chain_d = clear_i ? 1'b0 : hit_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= 1'b0;
    end else begin
      chain_q <= chain_d;
    end
  end

  assign chain_o = chain_q;

endmodule

@@ design/smc_accum.sv @@
// Per-text accumulation of match results and the result output register.
module smc_accum import smc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  scan_item_t            item_i,
  output logic                  in_ready_o,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [OUT_DATA_W-1:0] m_tdata_o
);

  `include "assert_macros.svh"

  logic             found_q, found_d, found_n;
  logic [IDX_W-1:0] first_q, first_d, first_n;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_n;
  logic             out_valid_q, out_valid_d;
  logic             out_found_q, out_found_d;
  logic [IDX_W-1:0] out_first_q, out_first_d;
  logic [CNT_W-1:0] out_cnt_q, out_cnt_d;
  logic             out_long_q, out_long_d;
  logic             go;

  // only a last item needs room in the output register
  assign in_ready_o = !item_i.last || !out_valid_q || m_tready_i;
  assign go         = in_valid_i && in_ready_o;

  // running results including this byte
  assign found_n = found_q | item_i.hit;
  assign first_n = (item_i.hit && !found_q) ? item_i.start : first_q;
  assign cnt_n   = (item_i.hit && (cnt_q != {CNT_W{1'b1}})) ? cnt_q + CNT_W'(1) : cnt_q;

  always_comb begin
    found_d     = found_q;
    first_d     = first_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_found_d = out_found_q;
    out_first_d = out_first_q;
    out_cnt_d   = out_cnt_q;
    out_long_d  = out_long_q;
    if (out_valid_q && m_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (go) begin
      if (item_i.last) begin
        found_d     = 1'b0;
        first_d     = '0;
        cnt_d       = '0;
        out_valid_d = 1'b1;
        out_found_d = found_n;
        out_first_d = first_n;
        out_cnt_d   = cnt_n;
        out_long_d  = item_i.too_long;
      end else begin
        found_d = found_n;
        first_d = first_n;
        cnt_d   = cnt_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      first_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      found_q     <= found_d;
      first_q     <= first_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_found_q <= out_found_d;
    out_first_q <= out_first_d;
    out_cnt_q   <= out_cnt_d;
    out_long_q  <= out_long_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{(OUT_DATA_W - OUT_FIELD_W){1'b0}},
                       out_long_q, out_cnt_q, out_first_q, out_found_q};

  // no match yet means nothing counted and no start recorded
  `ASSERT_P(a_idle_results, !found_q |-> (first_q == '0 && cnt_q == '0), "results without a match")
  // a result appears only after a last byte went through
  `ASSERT_P(a_out_after_last, $rose(out_valid_q) |-> $past(go && item_i.last), "result without last byte")
  // a first match is always counted
  `ASSERT_NEVER(a_found_uncounted, found_q && cnt_q == '0, "match flagged but count is zero")

endmodule

@@ design/substring_match_counter.sv @@
// Channel   | Direction | Contents
// s_axis    | in        | tdata[7:0] text_byte, tlast last_byte
// m_axis    | out       | tdata[0] found, [16:1] first_index, [32:17] match_count,
//           |           | [33] too_long, [39:34] zero
// cfg       | in        | cfg_index_i register index, cfg_data_i write data
//
// One text byte per cycle unless the scan stage is stalled; each byte updates the row of
// compare cells in the cycle it is taken, and its result is registered in the scan stage.
// A result item leaves from the output register after the last byte of its text is taken.
// Reset clears the pattern to length 1, value zero, and all per-text state.
// A stalled result only holds up the input once a further last byte waits.
module substring_match_counter import smc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // text bytes
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // [7:0] text_byte
  input  logic                  s_axis_tlast,
  // results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // found, first_index, match_count, too_long
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  `include "assert_macros.svh"

  logic [CFG_DATA_W-1:0]         pat_lo_q, pat_lo_d;
  logic [CFG_DATA_W-1:0]         pat_hi_q, pat_hi_d;
  logic [LEN_W-1:0]              pat_len_q, pat_len_d;
  logic [2*CFG_DATA_W-1:0]       pattern;
  logic [LEN_W-1:0]              eff_len;
  logic [LEN_W-1:0]              sel;
  logic [MAX_PATTERN-1:0]        hit_vec;
  logic [MAX_PATTERN-1:0]        chain_q;
  logic [MAX_PATTERN-1:0]        chain_in;
  logic [POS_W-1:0]              pos_q, pos_d;
  logic [POS_W-1:0]              start_full;
  logic                          accept;
  logic                          s1_valid_q, s1_valid_d;
  scan_item_t                    s1_item_q, s1_item_d;
  logic                          s1_ready;
  logic                          s1_go;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    pat_lo_d  = pat_lo_q;
    pat_hi_d  = pat_hi_q;
    pat_len_d = pat_len_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PAT_LO:  pat_lo_d  = cfg_data_i;
        CFG_PAT_HI:  pat_hi_d  = cfg_data_i;
        CFG_PAT_LEN: pat_len_d = cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      pat_len_q <= LEN_W'(1);
    end else begin
      pat_lo_q  <= pat_lo_d;
      pat_hi_q  <= pat_hi_d;
      pat_len_q <= pat_len_d;
    end
  end

  assign pattern = {pat_hi_q, pat_lo_q};

  // length zero acts as one, anything beyond the row as the full row
  always_comb begin
    if (pat_len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (pat_len_q > LEN_W'(MAX_PATTERN)) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = pat_len_q;
    end
  end

  assign sel    = eff_len - LEN_W'(1);
  assign accept = s_axis_tvalid && s_axis_tready;

  // row of compare cells, cell j tracks pattern bytes 0..j
  assign chain_in[0] = 1'b1;
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    if (j > 0) begin : g_link
      assign chain_in[j] = chain_q[j-1];
    end
    smc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (accept),
      .clear_i    (s_axis_tlast),
      .byte_i     (s_axis_tdata),
      .pat_byte_i (pattern[j*BYTE_W +: BYTE_W]),
      .chain_i    (chain_in[j]),
      .hit_o      (hit_vec[j]),
      .chain_o    (chain_q[j])
    );
  end

  // byte position within the text, saturating just past the limit
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (s_axis_tlast) begin
        pos_d = '0;
      end else if (pos_q < POS_W'(MAX_TEXT + 1)) begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  assign start_full = pos_q - POS_W'(eff_len) + POS_W'(1);

  // scan stage register between the cells and the accumulator
  assign s1_go         = s1_valid_q && s1_ready;
  assign s_axis_tready = !s1_valid_q || s1_ready;

  always_comb begin
    s1_item_d          = s1_item_q;
    s1_item_d.hit      = hit_vec[sel[SEL_W-1:0]];
    s1_item_d.last     = s_axis_tlast;
    s1_item_d.start    = start_full[IDX_W-1:0];
    s1_item_d.too_long = (pos_q >= POS_W'(MAX_TEXT));
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= s1_item_d;
    end
  end

  smc_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s1_valid_q),
    .item_i     (s1_item_q),
    .in_ready_o (s1_ready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata)
  );

  // a finished text leaves no partial match and no position behind
  `ASSERT_P(a_text_cleared, (accept && s_axis_tlast) |=> (chain_q == '0 && pos_q == '0), "text state not cleared")
  // a byte is never taken while the scan stage is stuck
  `ASSERT_NEVER(a_no_overrun, accept && s1_valid_q && !s1_go, "scan stage overwritten")

endmodule

@@ tb/sv/substring_match_counter_tb.sv @@
`timescale 1ns / 1ps

module substring_match_counter_tb;
  import smc_pkg::*;

  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 4;
  localparam int STALL_LIMIT    = 5000;
  localparam int SHOW_LIMIT     = 10;

  // Index with no register behind it; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // One report as it sits in m_axis_tdata, found in the lowest bit
  typedef struct packed {
    logic             too_long;
    logic [CNT_W-1:0] match_count;
    logic [IDX_W-1:0] first_index;
    logic             found;
  } match_report_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;  // [7:0] text_byte
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;  // found, first_index, match_count, too_long
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  substring_match_counter dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Idle rates and the long output stall request
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit rx_hold_req = 1'b0;

  // Run statistics
  int bytes_sent      = 0;
  int texts_sent      = 0;
  int regs_written    = 0;
  int reports_checked = 0;
  int mismatches      = 0;

  // Predictor: pattern registers
  logic [63:0]      pat_lo;
  logic [63:0]      pat_hi;
  logic [LEN_W-1:0] pat_len;

  // Predictor: per-text scan state
  logic [7:0]       window_bytes [MAX_PATTERN];
  int unsigned      window_fill;
  int unsigned      text_pos;
  logic             found_flag;
  logic [IDX_W-1:0] first_start;
  logic [CNT_W-1:0] match_total;

  match_report_t    pending_reports[$];

  function automatic void clear_text_state();
    foreach (window_bytes[k]) window_bytes[k] = 8'h00;
    window_fill = 0;
    text_pos    = 0;
    found_flag  = 1'b0;
    first_start = '0;
    match_total = '0;
  endfunction

  function automatic void model_reset();
    pat_lo  = '0;
    pat_hi  = '0;
    pat_len = 5'd1;
    clear_text_state();
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_PAT_LO:  pat_lo  = data;
      CFG_PAT_HI:  pat_hi  = data;
      CFG_PAT_LEN: pat_len = data[LEN_W-1:0];
      default: ;
    endcase
  endfunction

  // Length in use: zero acts as one, anything above the maximum is clipped
  function automatic int pattern_span();
    int m;
    m = pat_len;
    if (m == 0) m = 1;
    if (m > MAX_PATTERN) m = MAX_PATTERN;
    return m;
  endfunction

  function automatic logic [7:0] pattern_byte(input int j);
    return (j < 8) ? pat_lo[j*8 +: 8] : pat_hi[(j-8)*8 +: 8];
  endfunction

  // Shift one byte in, test the window and queue a report on the last byte
  function automatic void scan_text_byte(input logic [7:0] b, input logic last);
    int            m;
    int unsigned   idx;
    bit            hit;
    match_report_t rep;
    m   = pattern_span();
    idx = text_pos;
    for (int k = MAX_PATTERN - 1; k > 0; k--) window_bytes[k] = window_bytes[k-1];
    window_bytes[0] = b;
    if (window_fill < MAX_PATTERN) window_fill++;
    if (text_pos < MAX_TEXT + 1) text_pos++;
    if (window_fill >= m) begin
      hit = 1'b1;
      for (int j = 0; j < m; j++)
        if (pattern_byte(j) != window_bytes[m-1-j]) hit = 1'b0;
      if (hit) begin
        if (!found_flag) begin
          found_flag  = 1'b1;
          first_start = IDX_W'(idx - (m - 1));
        end
        if (match_total != '1) match_total++;
      end
    end
    if (last) begin
      rep.found       = found_flag;
      rep.first_index = found_flag ? first_start : '0;
      rep.match_count = match_total;
      rep.too_long    = (text_pos > MAX_TEXT);
      pending_reports.push_back(rep);
      clear_text_state();
    end
  endfunction

  function automatic void note_mismatch(input string what, input longint want,
                                        input longint got);
    mismatches++;
    if (mismatches <= SHOW_LIMIT)
      $display("report %0d: %s expected %0h, got %0h", reports_checked, what, want, got);
  endfunction

  function automatic void check_report(input logic [OUT_DATA_W-1:0] data);
    match_report_t got;
    match_report_t want;
    got = data[OUT_FIELD_W-1:0];
    if (pending_reports.size() == 0) begin
      note_mismatch("report with none pending, data", 0, data);
    end else begin
      want = pending_reports.pop_front();
      if (got.found != want.found) note_mismatch("found", want.found, got.found);
      if (got.first_index != want.first_index)
        note_mismatch("first_index", want.first_index, got.first_index);
      if (got.match_count != want.match_count)
        note_mismatch("match_count", want.match_count, got.match_count);
      if (got.too_long != want.too_long) note_mismatch("too_long", want.too_long, got.too_long);
      if (data[OUT_DATA_W-1:OUT_FIELD_W] != '0)
        note_mismatch("pad bits", 0, data[OUT_DATA_W-1:OUT_FIELD_W]);
    end
    reports_checked++;
  endfunction

  // Watch all three channels: register writes, text bytes, reports
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) apply_register(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) scan_text_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_report(m_axis_tdata);
    end
  end

  // Report sink: random stalls, or one long hold when asked
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no transfer on any channel
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_text(input logic [7:0] txt[$]);
    foreach (txt[k]) send_byte(txt[k], k == txt.size() - 1);
    texts_sent++;
  endtask

  // Stop offering bytes and let every pending report drain
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Leaves valid high so back-to-back writes need no gap
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    regs_written++;
  endtask

  task automatic program_pattern(input logic [63:0] lo, input logic [63:0] hi,
                                 input logic [LEN_W-1:0] len);
    logic [CFG_DATA_W-1:0] len_word;
    len_word = {$urandom, $urandom};
    len_word[LEN_W-1:0] = len;
    cfg_write(CFG_PAT_LO, lo);
    cfg_write(CFG_PAT_HI, hi);
    cfg_write(CFG_PAT_LEN, len_word);
    cfg_valid_i <= 1'b0;
  endtask

  // Reset pattern is one zero byte; zero is an ordinary text byte
  task automatic test_reset_pattern();
    logic [7:0] t[$];
    t = '{8'h00, 8'h05, 8'h00};
    send_text(t);
  endtask

  task automatic test_directed_patterns();
    logic [7:0] t[$];
    // overlapping matches
    wait_idle();
    program_pattern(64'h6161, 64'h0, 5'd2);
    t = '{8'h61, 8'h61, 8'h61};
    send_text(t);
    // text shorter than the pattern
    t = '{8'h61};
    send_text(t);
    // write to the unused index leaves the pattern alone
    wait_idle();
    cfg_write(CFG_UNUSED, '1);
    cfg_valid_i <= 1'b0;
    t = '{8'h61, 8'h61};
    send_text(t);
    // length zero acts as one
    wait_idle();
    program_pattern(64'h7F, 64'h0, 5'd0);
    t = '{8'h7F, 8'h80, 8'h7F};
    send_text(t);
    // length above the maximum, full-width pattern filling the window exactly
    wait_idle();
    program_pattern(64'h00FF_00FF_00FF_00FF, 64'h00FF_00FF_00FF_00FF, 5'd31);
    t = {};
    for (int k = 0; k < MAX_PATTERN; k++) t.push_back((k % 2 == 0) ? 8'hFF : 8'h00);
    send_text(t);
  endtask

  task automatic program_random_pattern();
    logic [63:0]      lo;
    logic [63:0]      hi;
    logic [7:0]       pb;
    logic [LEN_W-1:0] len;
    int               flavor;
    flavor = $urandom_range(9);
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (flavor == 0) pb = 8'h00;
      else if (flavor == 1) pb = 8'hFF;
      else if ($urandom_range(9) < 7) pb = 8'h61 + 8'($urandom_range(1));
      else pb = 8'($urandom);
      if (k < 8) lo[k*8 +: 8] = pb;
      else hi[(k-8)*8 +: 8] = pb;
    end
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: len = LEN_W'($urandom_range(1, 4));
      6:                len = LEN_W'(MAX_PATTERN);
      default:          len = LEN_W'($urandom_range(0, 31));
    endcase
    program_pattern(lo, hi, len);
  endtask

  // Mostly pattern-flavored text with planted copies, some pure noise
  task automatic send_random_text();
    logic [7:0] t[$];
    int         m;
    int         mode;
    int         len;
    int         at;
    m    = pattern_span();
    mode = $urandom_range(9);
    len  = ($urandom_range(9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 20);
    for (int k = 0; k < len; k++) begin
      if (mode < 7 && $urandom_range(3) != 0) t.push_back(pattern_byte($urandom_range(m - 1)));
      else t.push_back(8'($urandom));
    end
    if (mode < 5 && len >= m) begin
      at = $urandom_range(len - m);
      for (int k = 0; k < m; k++) t[at+k] = pattern_byte(k);
    end
    send_text(t);
  endtask

  task automatic test_random_texts(input int tx_pct, input int rx_pct, input int n_bytes);
    int target;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      wait_idle();
      program_random_pattern();
      repeat ($urandom_range(3, 8)) send_random_text();
    end
  endtask

  // Sink holds off while short texts keep coming, so the input must stall
  task automatic test_output_stall();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    wait_idle();
    program_pattern(64'h6261, 64'h0, 5'd2);
    rx_hold_req = 1'b1;
    for (int k = 0; k < 60; k++)
      send_byte(8'h61 + 8'($urandom_range(1)), $urandom_range(2) == 0);
    send_byte(8'h62, 1'b1);
    wait_idle();
  endtask

  initial begin
    model_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 9;
    rx_idle_pct = 51;
    test_reset_pattern();
    test_directed_patterns();
    test_random_texts(9, 51, 350);
    test_random_texts(51, 9, 350);
    test_random_texts(0, 0, 300);
    test_output_stall();
    wait_idle();

    if (pending_reports.size() != 0) begin
      $display("%0d reports never arrived", pending_reports.size());
      mismatches += pending_reports.size();
    end
    $display("Checked %0d reports from %0d texts (%0d bytes), %0d register writes",
             reports_checked, texts_sent, bytes_sent, regs_written);
    $display("Covered overlap, short texts, length clipping, ignored writes, input stalls");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/smc_pkg.sv
design/smc_cell.sv
design/smc_accum.sv
design/substring_match_counter.sv
tb/sv/substring_match_counter_tb.sv
